[hdl/uvsg_pkg.sv]
// uvsg_pkg: types, constants and the CORDIC angle table for the UV sphere vertex generator.
// Used by every module under hdl/. No dependencies.
`timescale 1ns / 1ps
package uvsg_pkg;

  localparam int MAX_GRID   = 256;
  localparam int FRAC_BITS  = 15;
  localparam int ITERS      = 30;
  localparam int CW         = 34;  // CORDIC datapath width (Q2.30 plus headroom)
  localparam int AW         = 33;  // signed residual angle width
  localparam int CNT_W      = 9;
  localparam int IDX_W      = 8;
  localparam int QW         = 16;  // texture word width; the texture path itself uses FRAC_BITS fraction bits
  localparam logic [CW-1:0] GAIN_INV = CW'(652032874);

  localparam logic [0:0] REG_RINGS   = 1'b0;
  localparam logic [0:0] REG_SECTORS = 1'b1;

  typedef struct packed {
    logic [7:0] ring_index;
    logic [7:0] sector_index;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic [15:0] corner_d;
    logic quad_valid;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] s;
    logic [CNT_W-1:0] rc;
    logic [CNT_W-1:0] sc;
  } job_t;

  function automatic logic [AW-1:0] atan_turn(input int i);
    logic [AW-1:0] t;
    unique case (i)
      0: t = AW'(32'h20000000);  1: t = AW'(32'h12E4051E);
      2: t = AW'(32'h09FB385B);  3: t = AW'(32'h051111D4);
      4: t = AW'(32'h028B0D43);  5: t = AW'(32'h0145D7E1);
      6: t = AW'(32'h00A2F61E);  7: t = AW'(32'h00517C55);
      8: t = AW'(32'h0028BE53);  9: t = AW'(32'h00145F2F);
      10: t = AW'(32'h000A2F98); 11: t = AW'(32'h000517CC);
      12: t = AW'(32'h00028BE6); 13: t = AW'(32'h000145F3);
      14: t = AW'(32'h0000A2F9); 15: t = AW'(32'h0000517C);
      16: t = AW'(32'h000028BE); 17: t = AW'(32'h0000145F);
      18: t = AW'(32'h00000A2F); 19: t = AW'(32'h00000517);
      20: t = AW'(32'h0000028B); 21: t = AW'(32'h00000145);
      22: t = AW'(32'h000000A2); 23: t = AW'(32'h00000051);
      24: t = AW'(32'h00000028); 25: t = AW'(32'h00000014);
      26: t = AW'(32'h0000000A); 27: t = AW'(32'h00000005);
      28: t = AW'(32'h00000002); 29: t = AW'(32'h00000001);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[hdl/uvsg_front.sv]
// uvsg_front: input handshake, count and index clamping, front register.
// Depends on uvsg_pkg.
`timescale 1ns / 1ps
module uvsg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uvsg_pkg::in_word_t in_data,
  input  logic [8:0]        rings_cfg,
  input  logic [8:0]        sectors_cfg,
  output logic              job_valid,
  input  logic              job_ready,
  output uvsg_pkg::job_t    job
);
  import uvsg_pkg::*;

  logic valid_r;
  job_t job_r, job_nxt;
  logic [CNT_W-1:0] rc, sc;

  always_comb begin
    rc = (rings_cfg < 9'd2) ? 9'd2 : (rings_cfg > 9'(MAX_GRID)) ? 9'(MAX_GRID) : rings_cfg;
    sc = (sectors_cfg < 9'd2) ? 9'd2 :
         (sectors_cfg > 9'(MAX_GRID)) ? 9'(MAX_GRID) : sectors_cfg;
    job_nxt.rc = rc;
    job_nxt.sc = sc;
    job_nxt.r = ({1'b0, in_data.ring_index} > rc - 9'd1) ? 8'(rc - 9'd1) : in_data.ring_index;
    job_nxt.s = ({1'b0, in_data.sector_index} > sc - 9'd1) ? 8'(sc - 9'd1)
                                                           : in_data.sector_index;
  end

  assign in_ready  = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      job_r <= job_nxt;
    end
  end
endmodule

[hdl/uvsg_fifo.sv]
// uvsg_fifo: two-entry queue between front and back.
// Depends on uvsg_pkg.
`timescale 1ns / 1ps
module uvsg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  uvsg_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output uvsg_pkg::job_t rd_data
);
  import uvsg_pkg::*;

  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("fifo count overflow");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !rd |=> cnt_r == 2'd2)
    else $error("fifo lost word");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 && !wr |=> !rd_valid)
    else $error("fifo invented word");
`endif
endmodule

[hdl/uvsg_back.sv]
// uvsg_back: angle and texture division, two pipelined CORDICs, products, indices, output register.
// Depends on uvsg_pkg. Stalls as one pipeline on out_ready.
`timescale 1ns / 1ps
module uvsg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  uvsg_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_ready,
  output uvsg_pkg::out_word_t out_data
);
  import uvsg_pkg::*;

  // stage layout: entry, NQ division stages (one quotient bit each), CORDIC, then tail
  localparam int NQ = 33;   // quotient bits of round(s*2^32/sd)
  localparam int DS = NQ;   // restoring division, one bit per stage
  localparam int CS = ITERS + 1;
  localparam int NS = DS + CS + 3;
  localparam int PW = 64;   // product width

  logic adv;
  logic [NS-1:0] v_r;
  assign adv = !v_r[NS-1] || out_ready;
  assign job_ready = adv;
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], job_valid};
  end

  // ---------------- division stages: four dividends share stages ---------
  // numerators: pol = r*2^31 + rd/2, az = s*2^32 + sd/2, u = s*2^15 + sd/2,
  // v = r*2^15 + rd/2. Bits above NQ seed the remainder; they stay below the divisor.
  typedef struct packed {
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] s;
    logic [CNT_W-1:0] sc;
    logic [CNT_W-1:0] rd;
    logic [CNT_W-1:0] sd;
  } meta_t;
  localparam int NW = 41;
  meta_t m_r [DS+1];
  logic [NW-1:0] pn_r [DS+1], an_r [DS+1];
  logic [NQ-1:0] un_r [DS+1], vn_r [DS+1];
  logic [CNT_W-1:0] prm_r [DS+1], arm_r [DS+1], urm_r [DS+1], vrm_r [DS+1];
  logic [NQ-1:0] pq_r [DS+1], aq_r [DS+1];
  logic [15:0] uq_r [DS+1], vq_r [DS+1];
  logic [CNT_W-1:0] rd0, sd0;
  logic [NW-1:0] pn0, an0;

  always_comb begin
    rd0 = job.rc - 9'd1;
    sd0 = job.sc - 9'd1;
    pn0 = (NW'(job.r) << 31) + NW'(rd0 >> 1);
    an0 = (NW'(job.s) << 32) + NW'(sd0 >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0].r  <= job.r;
      m_r[0].s  <= job.s;
      m_r[0].sc <= job.sc;
      m_r[0].rd <= rd0;
      m_r[0].sd <= sd0;
      pn_r[0] <= pn0;
      an_r[0] <= an0;
      un_r[0] <= (NQ'(job.s) << FRAC_BITS) + NQ'(sd0 >> 1);
      vn_r[0] <= (NQ'(job.r) << FRAC_BITS) + NQ'(rd0 >> 1);
      prm_r[0] <= CNT_W'(pn0[NW-1:NQ]);
      arm_r[0] <= CNT_W'(an0[NW-1:NQ]);
      urm_r[0] <= '0;
      vrm_r[0] <= '0;
      pq_r[0] <= '0;
      aq_r[0] <= '0;
      uq_r[0] <= '0;
      vq_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [CNT_W:0] pt, at, ut, vt;
    logic pge, age, uge, vge;
    always_comb begin
      pt = {prm_r[k], pn_r[k][NQ-1-k]};
      at = {arm_r[k], an_r[k][NQ-1-k]};
      ut = {urm_r[k], un_r[k][NQ-1-k]};
      vt = {vrm_r[k], vn_r[k][NQ-1-k]};
      pge = pt >= {1'b0, m_r[k].rd};
      age = at >= {1'b0, m_r[k].sd};
      uge = ut >= {1'b0, m_r[k].sd};
      vge = vt >= {1'b0, m_r[k].rd};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[k+1] <= m_r[k];
        pn_r[k+1] <= pn_r[k];
        an_r[k+1] <= an_r[k];
        un_r[k+1] <= un_r[k];
        vn_r[k+1] <= vn_r[k];
        prm_r[k+1] <= pge ? CNT_W'(pt - {1'b0, m_r[k].rd}) : CNT_W'(pt);
        arm_r[k+1] <= age ? CNT_W'(at - {1'b0, m_r[k].sd}) : CNT_W'(at);
        urm_r[k+1] <= uge ? CNT_W'(ut - {1'b0, m_r[k].sd}) : CNT_W'(ut);
        vrm_r[k+1] <= vge ? CNT_W'(vt - {1'b0, m_r[k].rd}) : CNT_W'(vt);
        pq_r[k+1] <= {pq_r[k][NQ-2:0], pge};
        aq_r[k+1] <= {aq_r[k][NQ-2:0], age};
        uq_r[k+1] <= {uq_r[k][14:0], uge};
        vq_r[k+1] <= {vq_r[k][14:0], vge};
      end
    end
  end

  // ---------------- CORDIC, both angles -----------------------------------
  logic signed [CW-1:0] px_r [CS], py_r [CS], ax_r [CS], ay_r [CS];
  logic signed [AW-1:0] pz_r [CS], az_r [CS];
  logic pf_r [CS], af_r [CS];
  meta_t cm_r [CS];
  logic [15:0] tu_r [CS], tv_r [CS];

  function automatic logic [AW:0] fold(input logic [31:0] ang);
    logic [31:0] a2;
    logic fl;
    fl = (ang + 32'h40000000) >= 32'h80000000;
    a2 = fl ? ang - 32'h80000000 : ang;
    return {fl, a2[31], a2};
  endfunction

  always_ff @(posedge clk) begin
    logic [AW:0] pf, af;
    pf = fold(pq_r[DS][31:0]);
    af = fold(aq_r[DS][31:0]);
    if (adv) begin
      px_r[0] <= GAIN_INV; py_r[0] <= '0; pz_r[0] <= pf[AW-1:0]; pf_r[0] <= pf[AW];
      ax_r[0] <= GAIN_INV; ay_r[0] <= '0; az_r[0] <= af[AW-1:0]; af_r[0] <= af[AW];
      cm_r[0] <= m_r[DS];
      tu_r[0] <= uq_r[DS];
      tv_r[0] <= vq_r[DS];
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_cor
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!pz_r[i][AW-1]) begin
          px_r[i+1] <= px_r[i] - (py_r[i] >>> i);
          py_r[i+1] <= py_r[i] + (px_r[i] >>> i);
          pz_r[i+1] <= pz_r[i] - atan_turn(i);
        end else begin
          px_r[i+1] <= px_r[i] + (py_r[i] >>> i);
          py_r[i+1] <= py_r[i] - (px_r[i] >>> i);
          pz_r[i+1] <= pz_r[i] + atan_turn(i);
        end
        if (!az_r[i][AW-1]) begin
          ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] - atan_turn(i);
        end else begin
          ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] + atan_turn(i);
        end
        pf_r[i+1] <= pf_r[i];
        af_r[i+1] <= af_r[i];
        cm_r[i+1] <= cm_r[i];
        tu_r[i+1] <= tu_r[i];
        tv_r[i+1] <= tv_r[i];
      end
    end
  end

  // ---------------- tail: products, rounding, indices, texture -----------
  localparam int L = CS - 1;
  logic signed [CW-1:0] cp, sp, ca, sa;
  assign cp = pf_r[L] ? -px_r[L] : px_r[L];
  assign sp = pf_r[L] ? -py_r[L] : py_r[L];
  assign ca = af_r[L] ? -ax_r[L] : ax_r[L];
  assign sa = af_r[L] ? -ay_r[L] : ay_r[L];

  // CORDIC outputs stay within 32 signed bits, so 32 x 32 products
  logic signed [PW-1:0] xp_r, zp_r;
  logic signed [CW-1:0] ny_r;
  meta_t t_r;
  logic [15:0] tex_u_r, tex_v_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      xp_r <= $signed(ca[31:0]) * $signed(sp[31:0]);
      zp_r <= $signed(sa[31:0]) * $signed(sp[31:0]);
      ny_r <= -cp;
      t_r <= cm_r[L];
      tex_u_r <= tu_r[L];
      tex_v_r <= tv_r[L];
    end
  end

  function automatic logic [15:0] pack(input logic signed [PW-1:0] v, input int n);
    logic signed [PW-1:0] q;
    q = (v + PW'(64'sd1 <<< (n - 1))) >>> n;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  out_word_t o_r, o_nxt;
  logic qv;
  logic [15:0] a, b2;
  always_comb begin
    qv = ({1'b0, t_r.r} < t_r.rd) && ({1'b0, t_r.s} < t_r.sd);
    a  = 16'(t_r.r) * 16'(t_r.sc) + 16'(t_r.s);
    b2 = a + 16'(t_r.sc);
    o_nxt.pos_x = pack(xp_r, 61 - FRAC_BITS);
    o_nxt.pos_y = pack(PW'(ny_r), 31 - FRAC_BITS);
    o_nxt.pos_z = pack(zp_r, 61 - FRAC_BITS);
    o_nxt.tex_u = tex_u_r;
    o_nxt.tex_v = tex_v_r;
    o_nxt.corner_a = a;
    o_nxt.corner_b = qv ? b2 : '0;
    o_nxt.corner_c = qv ? b2 + 16'd1 : '0;
    o_nxt.corner_d = qv ? a + 16'd1 : '0;
    o_nxt.quad_valid = qv;
  end

  always_ff @(posedge clk) begin
    if (adv) o_r <= o_nxt;
  end
  assign out_data = o_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");
  a_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.quad_valid |-> out_data.corner_b == 16'd0)
    else $error("corner set without quad");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |=> v_r[0])
    else $error("accepted job dropped");
`endif
endmodule

[hdl/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator, top level. An input word passes through the front register,
// the queue, the back entry and division stages, the CORDIC stages, and the product and
// output registers. Throughput: one word per cycle; the back pipeline stalls as a whole on
// out_ready while front and two-entry queue keep taking words until full.
// Reset: synchronous active-low rst_n clears valid state; the ring and sector count registers
// return to 16. Depends on uvsg_pkg, uvsg_front, uvsg_fifo, uvsg_back.
`timescale 1ns / 1ps
module uv_sphere_vertex_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uvsg_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output uvsg_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [8:0]          cfg_data
);
  import uvsg_pkg::*;

  logic [CNT_W-1:0] rings_r, sectors_r;
  logic fv, fr, qv, qr;
  job_t fj, qj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rings_r <= 9'd16;
      sectors_r <= 9'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RINGS:   rings_r <= cfg_data;
        REG_SECTORS: sectors_r <= cfg_data;
        default: ;
      endcase
    end
  end

  uvsg_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .rings_cfg(rings_r), .sectors_cfg(sectors_r),
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  uvsg_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qj)
  );

  uvsg_back u_back (
    .clk, .rst_n, .job_valid(qv), .job_ready(qr), .job(qj),
    .out_valid, .out_ready, .out_data
  );
endmodule

[tb/uv_sphere_vertex_generator_tb.sv]
// Self-checking testbench for uv_sphere_vertex_generator: random and directed grid points,
// with an integer CORDIC predictor compared field by field against each result word.
// Depends on uvsg_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_tb;
  import uvsg_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_RINGS;
  logic [8:0] cfg_data = '0;

  in_word_t pend_q[$];
  out_word_t vtx_q[$];
  logic [8:0] ring_reg = 9'd16;
  logic [8:0] sector_reg = 9'd16;
  int send_idle = 0;
  int recv_idle = 0;
  int err_cnt = 0;
  int cycles = 0;

  uv_sphere_vertex_generator u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint eff_count(logic [8:0] v);
    if (v < 2) return 2;
    if (v > MAX_GRID) return MAX_GRID;
    return v;
  endfunction

  // cos/sin of a 32-bit binary angle, Q2.30
  task automatic rotate(input logic [31:0] ang, output longint co, output longint si);
    bit flip;
    longint x, y, z, nx;
    logic [31:0] t;
    flip = 0;
    x = 652032874;
    y = 0;
    t = ang + 32'h40000000;
    if (t >= 32'h80000000) begin
      flip = 1;
      ang = ang - 32'h80000000;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_turn(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_turn(i));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    co = x;
    si = y;
  endtask

  function automatic logic [15:0] sat_pos(longint v, int n);
    longint lim;
    lim = 1 << (FRAC_BITS - 1);
    v = (v + (longint'(1) << (n - 1))) >>> n;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  task automatic predict_vertex(input in_word_t w, output out_word_t o);
    longint rc, sc, r, s, rd, sd, cp, sp, ca, sa;
    longint unsigned pol, az;
    rc = eff_count(ring_reg);
    sc = eff_count(sector_reg);
    r = w.ring_index;
    s = w.sector_index;
    if (r > rc - 1) r = rc - 1;
    if (s > sc - 1) s = sc - 1;
    rd = rc - 1;
    sd = sc - 1;
    pol = ((r << 31) + rd / 2) / rd;
    az = ((s << 32) + sd / 2) / sd;
    rotate(pol[31:0], cp, sp);
    rotate(az[31:0], ca, sa);
    o = '0;
    o.pos_x = sat_pos(ca * sp, 61 - FRAC_BITS);
    o.pos_y = sat_pos(-cp, 31 - FRAC_BITS);
    o.pos_z = sat_pos(sa * sp, 61 - FRAC_BITS);
    o.tex_u = 16'(((s << FRAC_BITS) + sd / 2) / sd);
    o.tex_v = 16'(((r << FRAC_BITS) + rd / 2) / rd);
    o.corner_a = 16'(r * sc + s);
    if (r < rd && s < sd) begin
      o.corner_b = 16'((r + 1) * sc + s);
      o.corner_c = 16'((r + 1) * sc + s + 1);
      o.corner_d = 16'(r * sc + s + 1);
      o.quad_valid = 1'b1;
    end
  endtask

  function automatic void cmp(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      err_cnt++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    out_word_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_vertex(in_data, p);
        vtx_q = {vtx_q, p};
      end
      if (!in_valid || in_ready) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data <= pend_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (vtx_q.size() == 0) begin
          $error("unexpected result word");
          err_cnt++;
        end else begin
          e = vtx_q.pop_front();
          cmp("pos_x", e.pos_x, out_data.pos_x);
          cmp("pos_y", e.pos_y, out_data.pos_y);
          cmp("pos_z", e.pos_z, out_data.pos_z);
          cmp("tex_u", e.tex_u, out_data.tex_u);
          cmp("tex_v", e.tex_v, out_data.tex_v);
          cmp("corner_a", e.corner_a, out_data.corner_a);
          cmp("corner_b", e.corner_b, out_data.corner_b);
          cmp("corner_c", e.corner_c, out_data.corner_c);
          cmp("corner_d", e.corner_d, out_data.corner_d);
          cmp("quad_valid", 16'(e.quad_valid), 16'(out_data.quad_valid));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("uv_sphere_vertex_generator_tb: FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pend_q.size() > 0 || in_valid || vtx_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RINGS) ring_reg = val;
    else sector_reg = val;
  endtask

  task automatic push_point(int r, int s);
    in_word_t w;
    w.ring_index = 8'(r);
    w.sector_index = 8'(s);
    pend_q = {pend_q, w};
  endtask

  task automatic push_random(int n);
    int rc, sc;
    rc = int'(eff_count(ring_reg));
    sc = int'(eff_count(sector_reg));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) push_point($urandom_range(rc - 1), $urandom_range(sc - 1));
      else push_point($urandom_range(255), $urandom_range(255));
    end
  endtask

  initial begin
    logic [8:0] rings_set[9] = '{9'd16, 9'd2, 9'd256, 9'd0, 9'd511, 9'd3, 9'd200, 9'd1, 9'd0};
    logic [8:0] sects_set[9] = '{9'd16, 9'd2, 9'd256, 9'd1, 9'd300, 9'd17, 9'd5, 9'd129, 9'd0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 21;
    recv_idle = 83;
    // directed: poles, last ring/sector, clamping, reset counts
    push_point(0, 0);
    push_point(255, 255);
    push_point(15, 15);
    push_point(14, 14);
    push_point(0, 15);
    push_point(15, 0);
    push_point(7, 8);
    push_point(8, 4);
    push_point(16, 3);
    push_point(3, 16);
    push_point(170, 85);
    push_point(85, 170);
    drain();
    for (int k = 0; k < 9; k++) begin
      if (k == 3) begin
        send_idle = 83;
        recv_idle = 21;
      end else if (k == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (k == 8) begin
        rings_set[k] = 9'($urandom_range(2, 256));
        sects_set[k] = 9'($urandom_range(2, 256));
      end
      write_reg(REG_RINGS, rings_set[k]);
      write_reg(REG_SECTORS, sects_set[k]);
      push_point(0, 0);
      push_point(255, 255);
      push_random(80);
      // hold off until all results are back, then continue
      drain();
      push_random(90);
      drain();
    end
    if (err_cnt == 0) begin
      $display("uv_sphere_vertex_generator_tb: PASS");
    end else begin
      $display("uv_sphere_vertex_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
